/* rtl/core/amrb_pkg.sv */
// ----------------------------------------------------------------------------
// amrb_pkg
// Shared types, sizes and codes for the aligned message ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package amrb_pkg;

   // Ring geometry. RING_BYTES and LINE_BYTES must be powers of two, since
   // wrapping and line rounding are done by masking.
   localparam int RING_BYTES   = 4096;
   localparam int LINE_BYTES   = 64;
   localparam int HEADER_BYTES = 4;

   // Fixed field widths of the item interfaces.
   localparam int CMD_W    = 2;
   localparam int LEN_W    = 12;
   localparam int DATA_W   = 8;
   localparam int STATUS_W = 3;
   localparam int BATCH_W  = 12;
   localparam int LIMIT_W  = 13;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2048);

   // Derived sizes.
   localparam int RING_AW  = $clog2(RING_BYTES);
   localparam int HCNT_W   = $clog2(HEADER_BYTES);
   localparam int HDR_BITS = HEADER_BYTES * DATA_W;
   localparam int TOTAL_W  = $clog2(HEADER_BYTES + (1 << LEN_W) + LINE_BYTES);
   localparam int CMP_A    = (TOTAL_W > LIMIT_W) ? TOTAL_W : LIMIT_W;
   localparam int CMP_W    = (CMP_A > RING_AW + 1) ? CMP_A : RING_AW + 1;

   localparam logic [TOTAL_W-1:0] TOTAL_ROUND = TOTAL_W'(HEADER_BYTES + LINE_BYTES - 1);
   localparam logic [TOTAL_W-1:0] TOTAL_MASK  = ~TOTAL_W'(LINE_BYTES - 1);

   localparam int REQ_TDATA_W = ((LEN_W + DATA_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((BATCH_W + DATA_W + 7) / 8) * 8;

   // Item commands.
   typedef enum logic [CMD_W-1:0] {
      CMD_BEGIN   = 2'd0,
      CMD_PAYLOAD = 2'd1,
      CMD_FETCH   = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      RSP_OK        = 3'd0,
      RSP_FWD_LIMIT = 3'd1,
      RSP_NO_SPACE  = 3'd2,
      RSP_EMPTY     = 3'd3,
      RSP_BUSY      = 3'd4,
      RSP_SEQ       = 3'd5
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_HDR,
      S_RD_ZERO,
      S_DONE
   } fsm_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_en;
      logic load_in;
      logic rd_issue;
      logic hdr_wr;
      logic rd_zero;
      logic commit;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    ok;
      logic    clear_last;
      logic    hdr_last;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/core/amrb_ram.sv */
// ----------------------------------------------------------------------------
// amrb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module amrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/amrb_ctrl.sv */
// ----------------------------------------------------------------------------
// amrb_ctrl
// Sequencer for the ring buffer: clearing pass, item execution steps and the
// result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module amrb_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire amrb_pkg::sts_type sts,
   output amrb_pkg::ctl_type     ctl
);

   amrb_pkg::fsm_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;

   // The result register can take a new item when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         amrb_pkg::S_CLEAR: begin
            if (sts.clear_last) state_in = amrb_pkg::S_IDLE;
         end
         amrb_pkg::S_IDLE: begin
            if (req_tvalid) state_in = amrb_pkg::S_EXEC;
         end
         amrb_pkg::S_EXEC: begin
            if (sts.ok && sts.cmd == amrb_pkg::CMD_BEGIN) begin
               state_in = amrb_pkg::S_HDR;
            end else if (sts.ok && sts.cmd == amrb_pkg::CMD_READ) begin
               state_in = amrb_pkg::S_RD_ZERO;
            end else begin
               state_in = amrb_pkg::S_DONE;
            end
         end
         amrb_pkg::S_HDR: begin
            if (sts.hdr_last) state_in = amrb_pkg::S_DONE;
         end
         amrb_pkg::S_RD_ZERO: begin
            state_in = amrb_pkg::S_DONE;
         end
         amrb_pkg::S_DONE: begin
            if (out_free) state_in = amrb_pkg::S_IDLE;
         end
         default: begin
            state_in = amrb_pkg::S_CLEAR;
         end
      endcase
   end

   // Outputs decoded from the state.
   always_comb begin
      ctl            = '0;
      req_tready     = 1'b0;
      case (state_ff)
         amrb_pkg::S_CLEAR: begin
            ctl.clear_en = 1'b1;
         end
         amrb_pkg::S_IDLE: begin
            req_tready  = 1'b1;
            ctl.load_in = req_tvalid;
         end
         amrb_pkg::S_EXEC: begin
            ctl.rd_issue = 1'b1;
         end
         amrb_pkg::S_HDR: begin
            ctl.hdr_wr = 1'b1;
         end
         amrb_pkg::S_RD_ZERO: begin
            ctl.rd_zero = 1'b1;
         end
         amrb_pkg::S_DONE: begin
            ctl.commit = out_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   // Result valid: set when an item commits, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= amrb_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/core/amrb_dp.sv */
// ----------------------------------------------------------------------------
// amrb_dp
// Datapath of the ring buffer: ring memory, pointers, admission checks and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module amrb_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire amrb_pkg::ctl_type                     ctl,
   output amrb_pkg::sts_type                          sts,
   input  wire logic [amrb_pkg::CMD_W-1:0]            req_tuser,
   input  wire logic [amrb_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  wire logic                                  csr_we,
   input  wire logic [amrb_pkg::LIMIT_W-1:0]          csr_wdata,
   output logic      [amrb_pkg::STATUS_W-1:0]         rsp_tuser,
   output logic      [amrb_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                       rsp_tlast
);

   localparam int AW = amrb_pkg::RING_AW;

   // Latched input item.
   amrb_pkg::cmd_type                cmd_ff;
   logic [amrb_pkg::LEN_W-1:0]       len_ff;
   logic [amrb_pkg::DATA_W-1:0]      din_ff;

   // Pointers and flags.
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] reserve_ff, reserve_in;
   logic [AW-1:0] commit_ff, commit_in;
   logic [AW-1:0] write_ff, write_in;
   logic [AW-1:0] read_ff, read_in;
   logic [AW-1:0] batch_end_ff, batch_end_in;
   logic [amrb_pkg::LEN_W-1:0] left_ff, left_in;
   logic insert_open_ff, insert_open_in;
   logic batch_open_ff, batch_open_in;
   logic [amrb_pkg::LIMIT_W-1:0] limit_ff;

   // Clearing pass and header counters.
   logic [AW-1:0]                clr_cnt_ff;
   logic [amrb_pkg::HCNT_W-1:0]  hcnt_ff;

   // Result register.
   amrb_pkg::status_type           status_ff;
   logic [amrb_pkg::BATCH_W-1:0]   batch_ff;
   logic [amrb_pkg::DATA_W-1:0]    dout_ff;
   logic                           last_ff;

   // Combinational terms.
   logic [AW-1:0]                  ahead;
   logic [AW-1:0]                  occupied;
   logic [amrb_pkg::TOTAL_W-1:0]   total;
   logic [amrb_pkg::CMP_W-1:0]     room;
   logic                           fwd_hit;
   logic                           no_space;
   amrb_pkg::status_type           status;
   logic [amrb_pkg::HDR_BITS-1:0]  hdr_word;
   logic [amrb_pkg::DATA_W-1:0]    hdr_byte;
   logic [AW-1:0]                  hdr_addr;
   logic [AW-1:0]                  reserve_next;
   logic [AW-1:0]                  read_next;
   logic                           read_end;
   logic                           cmt_ok;

   // Memory port signals.
   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic [amrb_pkg::DATA_W-1:0]    wr_data;
   logic [amrb_pkg::DATA_W-1:0]    rd_data;

   // Take in an item when the controller accepts it.
   always_ff @(posedge clock) begin
      if (ctl.load_in) begin
         cmd_ff <= amrb_pkg::cmd_type'(req_tuser);
         len_ff <= req_tdata[amrb_pkg::LEN_W-1:0];
         din_ff <= req_tdata[amrb_pkg::LEN_W +: amrb_pkg::DATA_W];
      end
   end

   // Forward limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= amrb_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // Reserved distance ahead of head, and the line-padded message size.
   assign ahead    = reserve_ff - head_ff;
   assign occupied = commit_ff - head_ff;
   assign total    = (amrb_pkg::TOTAL_ROUND + amrb_pkg::TOTAL_W'(len_ff))
                     & amrb_pkg::TOTAL_MASK;
   assign room     = amrb_pkg::CMP_W'(amrb_pkg::RING_BYTES) - amrb_pkg::CMP_W'(ahead);
   assign fwd_hit  = amrb_pkg::CMP_W'(ahead) >= amrb_pkg::CMP_W'(limit_ff);
   assign no_space = amrb_pkg::CMP_W'(total) >= room;

   // Status of the latched item against the current pointers.
   always_comb begin
      status = amrb_pkg::RSP_OK;
      case (cmd_ff)
         amrb_pkg::CMD_BEGIN: begin
            if (insert_open_ff)  status = amrb_pkg::RSP_SEQ;
            else if (fwd_hit)    status = amrb_pkg::RSP_FWD_LIMIT;
            else if (no_space)   status = amrb_pkg::RSP_NO_SPACE;
         end
         amrb_pkg::CMD_PAYLOAD: begin
            if (!insert_open_ff) status = amrb_pkg::RSP_SEQ;
         end
         amrb_pkg::CMD_FETCH: begin
            if (batch_open_ff)                status = amrb_pkg::RSP_SEQ;
            else if (reserve_ff == head_ff)   status = amrb_pkg::RSP_EMPTY;
            else if (reserve_ff != commit_ff) status = amrb_pkg::RSP_BUSY;
         end
         amrb_pkg::CMD_READ: begin
            if (!batch_open_ff) status = amrb_pkg::RSP_SEQ;
         end
         default: begin
            status = amrb_pkg::RSP_SEQ;
         end
      endcase
   end

   // Header bytes, little endian, one per cycle.
   assign hdr_word = amrb_pkg::HDR_BITS'(total);
   assign hdr_byte = hdr_word[amrb_pkg::DATA_W*hcnt_ff +: amrb_pkg::DATA_W];
   assign hdr_addr = reserve_ff + AW'(hcnt_ff);

   always_ff @(posedge clock) begin
      if (ctl.load_in) begin
         hcnt_ff <= '0;
      end else if (ctl.hdr_wr) begin
         hcnt_ff <= hcnt_ff + amrb_pkg::HCNT_W'(1);
      end
   end

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (ctl.clear_en) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   assign cmt_ok = ctl.commit && (status == amrb_pkg::RSP_OK);

   // Memory write port: clearing, header, read-clear and payload bytes.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = write_ff;
      wr_data = din_ff;
      if (ctl.clear_en) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else if (ctl.hdr_wr) begin
         wr_en   = 1'b1;
         wr_addr = hdr_addr;
         wr_data = hdr_byte;
      end else if (ctl.rd_zero) begin
         wr_en   = 1'b1;
         wr_addr = read_ff;
         wr_data = '0;
      end else if (cmt_ok && cmd_ff == amrb_pkg::CMD_PAYLOAD) begin
         wr_en   = 1'b1;
      end
   end

   amrb_ram #(
      .WIDTH (amrb_pkg::DATA_W),
      .DEPTH (amrb_pkg::RING_BYTES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_issue),
      .rd_addr (read_ff),
      .rd_data (rd_data)
   );

   // Pointer updates when an item commits.
   assign reserve_next = reserve_ff + AW'(total);
   assign read_next    = read_ff + AW'(1);
   assign read_end     = read_next == batch_end_ff;

   always_comb begin
      head_in        = head_ff;
      reserve_in     = reserve_ff;
      commit_in      = commit_ff;
      write_in       = write_ff;
      read_in        = read_ff;
      batch_end_in   = batch_end_ff;
      left_in        = left_ff;
      insert_open_in = insert_open_ff;
      batch_open_in  = batch_open_ff;
      if (cmt_ok) begin
         case (cmd_ff)
            amrb_pkg::CMD_BEGIN: begin
               write_in   = reserve_ff + AW'(amrb_pkg::HEADER_BYTES);
               reserve_in = reserve_next;
               left_in    = len_ff;
               if (len_ff == '0) commit_in = reserve_next;
               else              insert_open_in = 1'b1;
            end
            amrb_pkg::CMD_PAYLOAD: begin
               write_in = write_ff + AW'(1);
               left_in  = left_ff - amrb_pkg::LEN_W'(1);
               if (left_ff == amrb_pkg::LEN_W'(1)) begin
                  commit_in      = reserve_ff;
                  insert_open_in = 1'b0;
               end
            end
            amrb_pkg::CMD_FETCH: begin
               read_in       = head_ff;
               batch_end_in  = commit_ff;
               batch_open_in = 1'b1;
            end
            amrb_pkg::CMD_READ: begin
               read_in = read_next;
               if (read_end) begin
                  head_in       = batch_end_ff;
                  batch_open_in = 1'b0;
               end
            end
            default: begin
               head_in = head_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         reserve_ff     <= '0;
         commit_ff      <= '0;
         write_ff       <= '0;
         read_ff        <= '0;
         batch_end_ff   <= '0;
         left_ff        <= '0;
         insert_open_ff <= 1'b0;
         batch_open_ff  <= 1'b0;
      end else begin
         head_ff        <= head_in;
         reserve_ff     <= reserve_in;
         commit_ff      <= commit_in;
         write_ff       <= write_in;
         read_ff        <= read_in;
         batch_end_ff   <= batch_end_in;
         left_ff        <= left_in;
         insert_open_ff <= insert_open_in;
         batch_open_ff  <= batch_open_in;
      end
   end

   // Result register, loaded as the item commits.
   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         status_ff <= status;
         batch_ff  <= (cmt_ok && cmd_ff == amrb_pkg::CMD_FETCH)
                      ? amrb_pkg::BATCH_W'(occupied) : '0;
         dout_ff   <= (cmt_ok && cmd_ff == amrb_pkg::CMD_READ) ? rd_data : '0;
         last_ff   <= cmt_ok && cmd_ff == amrb_pkg::CMD_READ && read_end;
      end
   end

   assign rsp_tuser = status_ff;
   assign rsp_tdata = amrb_pkg::RSP_TDATA_W'({dout_ff, batch_ff});
   assign rsp_tlast = last_ff;

   // Status towards the controller.
   assign sts.cmd        = cmd_ff;
   assign sts.ok         = status == amrb_pkg::RSP_OK;
   assign sts.clear_last = clr_cnt_ff == '1;
   assign sts.hdr_last   = hcnt_ff == amrb_pkg::HCNT_W'(amrb_pkg::HEADER_BYTES - 1);

endmodule

`default_nettype wire

/* rtl/core/aligned_message_ring_buffer_unit.sv */
// Sequence. Each accepted item goes through the execute state, then the header
// state (accepted begin) or read-clear state (accepted read), then done.
// Throughput: one item in flight; the next item is taken once the result has
// moved into the output register.
// Reset: synchronous; afterwards a clearing pass zeroes the ring, one byte a
// cycle over all RING_BYTES (4096) bytes, before the first item is accepted.
// ----------------------------------------------------------------------------
// aligned_message_ring_buffer_unit
// Byte ring of length-prefixed messages padded to whole lines, with a
// producer insert path and a consumer batch read path.
// ----------------------------------------------------------------------------
`default_nettype none

module aligned_message_ring_buffer_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input item channel.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [amrb_pkg::REQ_TDATA_W-1:0]  req_tdata,  // msg_len, data_in, zero pad
   input  wire logic [amrb_pkg::CMD_W-1:0]        req_tuser,  // cmd
   // Result item channel.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [amrb_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // batch_bytes, data_out, zero pad
   output logic      [amrb_pkg::STATUS_W-1:0]     rsp_tuser,  // status
   output logic                                   rsp_tlast,  // out_last
   // Forward limit register write.
   input  wire logic                              csr_we,
   input  wire logic [amrb_pkg::LIMIT_W-1:0]      csr_wdata
);

   amrb_pkg::ctl_type ctl;
   amrb_pkg::sts_type sts;

   // Sequencer.
   amrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   // Memory, pointers and result register.
   amrb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

`default_nettype wire

/* rtl/core/amrb_checker.sv */
// ----------------------------------------------------------------------------
// amrb_checker
// Port-level checks on the ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module amrb_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [amrb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [amrb_pkg::STATUS_W-1:0]    rsp_tuser,
   input wire logic                             rsp_tlast
);

   // A result that is not taken keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Only one item is worked on at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while another was in progress");

   // The clearing pass keeps the input closed straight after reset.
   a_reset_closed: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block open directly after reset");

   // The end of a batch is only flagged on a successful read.
   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == amrb_pkg::RSP_OK)
      else $error("last flag on a failed item");

   // A refused item returns no data.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != amrb_pkg::RSP_OK |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("data on a failed item");

endmodule

bind aligned_message_ring_buffer_unit amrb_checker u_amrb_checker (.*);

`default_nettype wire

/* bench/amrb_ring_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// amrb_ring_monitor
// Watches the item, result and register ports of the message ring buffer,
// keeps a shadow copy of the ring, its pointers and the forward limit, works
// out the result of every accepted item and checks each returned result
// against the oldest one still awaited.
// ----------------------------------------------------------------------------

module amrb_ring_monitor
   import amrb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // msg_len, data_in, zero pad
   input  logic [CMD_W-1:0]       req_tuser,  // cmd
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,  // batch_bytes, data_out, zero pad
   input  logic [STATUS_W-1:0]    rsp_tuser,  // status
   input  logic                   rsp_tlast,  // out_last
   input  logic                   csr_we,
   input  logic [LIMIT_W-1:0]     csr_wdata,
   output int                     fail_count,
   output int                     backlog
);

   typedef struct packed {
      status_type         status;
      logic [BATCH_W-1:0] batch_bytes;
      logic [DATA_W-1:0]  data_out;
      logic               last;
   } ring_reply_type;

   // Shadow of the ring contents, its pointers and the limit register.
   logic [DATA_W-1:0]  ring_mem [RING_BYTES];
   logic [RING_AW-1:0] head_at;
   logic [RING_AW-1:0] reserve_at;
   logic [RING_AW-1:0] commit_at;
   logic [RING_AW-1:0] fill_at;
   logic [RING_AW-1:0] read_at;
   logic [RING_AW-1:0] batch_stop;
   logic [LEN_W-1:0]   payload_due;
   logic               insert_busy;
   logic               batch_busy;
   logic [LIMIT_W-1:0] fwd_limit;

   ring_reply_type awaited[$];
   int             faults;

   // Applies one item to the shadow state and returns the result it gives.
   function automatic ring_reply_type ring_apply(input cmd_type cmd,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [DATA_W-1:0] din);
      ring_reply_type     r;
      logic [RING_AW-1:0] ahead;
      logic [RING_AW-1:0] p;
      int                 span;
      r = '{status: RSP_OK, batch_bytes: '0, data_out: '0, last: 1'b0};
      case (cmd)
         CMD_BEGIN: begin
            ahead = reserve_at - head_at;
            if (insert_busy) begin
               r.status = RSP_SEQ;
            end else if (ahead >= fwd_limit) begin
               r.status = RSP_FWD_LIMIT;
            end else begin
               // Header plus payload, rounded up to whole lines.
               span = ((HEADER_BYTES + len + LINE_BYTES - 1) / LINE_BYTES) * LINE_BYTES;
               if (span >= RING_BYTES - ahead) begin
                  r.status = RSP_NO_SPACE;
               end else begin
                  // Little-endian length header, wrapping like the payload.
                  p = reserve_at;
                  for (int i = 0; i < HEADER_BYTES; i++) begin
                     ring_mem[p] = DATA_W'(span >> (8 * i));
                     p++;
                  end
                  fill_at = p;
                  reserve_at = reserve_at + RING_AW'(span);
                  payload_due = len;
                  if (len == 0) begin
                     commit_at = reserve_at;
                  end else begin
                     insert_busy = 1'b1;
                  end
               end
            end
         end
         CMD_PAYLOAD: begin
            if (!insert_busy) begin
               r.status = RSP_SEQ;
            end else begin
               ring_mem[fill_at] = din;
               fill_at++;
               payload_due--;
               if (payload_due == 0) begin
                  commit_at = reserve_at;
                  insert_busy = 1'b0;
               end
            end
         end
         CMD_FETCH: begin
            if (batch_busy) begin
               r.status = RSP_SEQ;
            end else if (reserve_at == head_at) begin
               r.status = RSP_EMPTY;
            end else if (reserve_at != commit_at) begin
               r.status = RSP_BUSY;
            end else begin
               r.batch_bytes = BATCH_W'(commit_at - head_at);
               read_at = head_at;
               batch_stop = commit_at;
               batch_busy = 1'b1;
            end
         end
         CMD_READ: begin
            if (!batch_busy) begin
               r.status = RSP_SEQ;
            end else begin
               // Reads clear the byte, so padding is always zero later on.
               r.data_out = ring_mem[read_at];
               ring_mem[read_at] = '0;
               read_at++;
               if (read_at == batch_stop) begin
                  head_at = batch_stop;
                  batch_busy = 1'b0;
                  r.last = 1'b1;
               end
            end
         end
      endcase
      return r;
   endfunction

   // Reports one field that differs from its awaited value.
   function automatic bit field_wrong(input string field, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
      if (got_v === want_v) return 1'b0;
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      ring_reply_type want;
      bit             bad;
      if (reset) begin
         for (int i = 0; i < RING_BYTES; i++) ring_mem[i] = '0;
         head_at = '0;
         reserve_at = '0;
         commit_at = '0;
         fill_at = '0;
         read_at = '0;
         batch_stop = '0;
         payload_due = '0;
         insert_busy = 1'b0;
         batch_busy = 1'b0;
         fwd_limit = LIMIT_RESET;
         awaited.delete();
         faults = 0;
      end else begin
         if (csr_we) fwd_limit = csr_wdata;

         // Compare a returned result with the oldest awaited one.
         if (rsp_tvalid && rsp_tready) begin
            if (awaited.size() == 0) begin
               $display("%0t: result expected none, got status %0d", $time, rsp_tuser);
               faults++;
            end else begin
               want = awaited.pop_front();
               bad = field_wrong("status", 16'(want.status), 16'(rsp_tuser))
                   | field_wrong("batch_bytes", 16'(want.batch_bytes),
                                 16'(rsp_tdata[BATCH_W-1:0]))
                   | field_wrong("data_out", 16'(want.data_out),
                                 16'(rsp_tdata[BATCH_W +: DATA_W]))
                   | field_wrong("out_last", 16'(want.last), 16'(rsp_tlast));
               if (bad) faults++;
            end
         end

         // Work out the result of a newly accepted item.
         if (req_tvalid && req_tready) begin
            awaited.push_back(ring_apply(cmd_type'(req_tuser), req_tdata[LEN_W-1:0],
                                         req_tdata[LEN_W +: DATA_W]));
         end
      end
      fail_count <= faults;
      backlog <= awaited.size();
   end

endmodule

/* bench/aligned_message_ring_buffer_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aligned_message_ring_buffer_unit_test
// Drives the message ring buffer with directed and random item sequences:
// whole messages, batch fetches and full batch reads, mixed with items out
// of sequence, under several forward limits and random stalls on both sides.
// ----------------------------------------------------------------------------

module aligned_message_ring_buffer_unit_test;

   import amrb_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 12;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;  // msg_len, data_in, zero pad
   logic [CMD_W-1:0]       req_tuser;  // cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // batch_bytes, data_out, zero pad
   logic [STATUS_W-1:0]    rsp_tuser;  // status
   logic                   rsp_tlast;  // out_last
   logic                   csr_we;
   logic [LIMIT_W-1:0]     csr_wdata;

   int                 fail_count;
   int                 backlog;
   int                 sent;
   int                 rsp_seen;
   status_type         reply_status;
   logic [BATCH_W-1:0] reply_batch;
   int                 batch_left;
   bit                 gap_on;
   bit                 calm;
   bit                 long_hold_due;
   bit                 long_hold_done;

   aligned_message_ring_buffer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   amrb_ring_monitor ring_watch (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .backlog    (backlog)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Keep the last result so that the stimulus can follow the block's replies.
   initial rsp_seen = 0;
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         rsp_seen <= rsp_seen + 1;
         reply_status <= status_type'(rsp_tuser);
         reply_batch <= rsp_tdata[BATCH_W-1:0];
      end
   end

   // Offers one item and waits until it is accepted, with an occasional gap first.
   task automatic send_item(input cmd_type cmd, input logic [LEN_W-1:0] len,
                            input logic [DATA_W-1:0] din);
      if (gap_on && !calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {{(REQ_TDATA_W - LEN_W - DATA_W){1'b0}}, din, len};
      do @(posedge clock); while (!req_tready);
      sent++;
      if (sent % 64 == 0) gap_on = ($urandom_range(0, 3) != 0);
   endtask

   // Waits for the result of the last accepted item.
   task automatic wait_reply();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (rsp_seen != sent);
   endtask

   // Waits until every result is back and the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (rsp_seen != sent);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(input logic [LIMIT_W-1:0] value);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One message: a begin item, then its payload if the block takes it.
   task automatic insert_message(input bit lean);
      int len;
      int pick;
      pick = $urandom_range(0, 99);
      if (lean && pick < 85) len = 0;
      else if (pick < 50) len = $urandom_range(0, 8);
      else if (pick < 78) len = $urandom_range(9, 62);
      else if (pick < 92) len = $urandom_range(63, 250);
      else len = $urandom_range(4029, 4095);
      send_item(CMD_BEGIN, LEN_W'(len), DATA_W'($urandom_range(0, 255)));
      wait_reply();
      if (reply_status == RSP_OK) begin
         for (int i = 0; i < len; i++) begin
            // Now and then an item out of sequence in the middle of a message.
            if ($urandom_range(0, 39) == 0) begin
               send_item($urandom_range(0, 1) ? CMD_FETCH : CMD_BEGIN,
                         LEN_W'($urandom_range(0, 4095)), DATA_W'($urandom_range(0, 255)));
            end
            send_item(CMD_PAYLOAD, LEN_W'($urandom_range(0, 4095)),
                      DATA_W'($urandom_range(0, 255)));
         end
      end
   endtask

   // Fetches a batch if none is open and reads it out to its last byte.
   task automatic drain_batch();
      if (batch_left == 0) begin
         send_item(CMD_FETCH, LEN_W'($urandom_range(0, 4095)), DATA_W'($urandom_range(0, 255)));
         wait_reply();
         if (reply_status == RSP_OK) batch_left = reply_batch;
      end
      if (batch_left >= LINE_BYTES && !long_hold_done) long_hold_due = 1'b1;
      while (batch_left > 0) begin
         if ($urandom_range(0, 49) == 0) begin
            insert_message(1'b0);
         end else if ($urandom_range(0, 49) == 0) begin
            send_item(CMD_FETCH, LEN_W'($urandom_range(0, 4095)),
                      DATA_W'($urandom_range(0, 255)));
         end
         send_item(CMD_READ, LEN_W'($urandom_range(0, 4095)), DATA_W'($urandom_range(0, 255)));
         batch_left--;
      end
   endtask

   task automatic stray_item();
      if (batch_left == 0 && $urandom_range(0, 1) == 1) begin
         send_item(CMD_READ, LEN_W'($urandom_range(0, 4095)), DATA_W'($urandom_range(0, 255)));
      end else begin
         send_item(CMD_PAYLOAD, LEN_W'($urandom_range(0, 4095)),
                   DATA_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_phase(input int count, input int drain_pct, input bit lean);
      int stop_at;
      int pick;
      stop_at = sent + count;
      while (sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < drain_pct) drain_batch();
         else if (pick < 90) insert_message(lean);
         else stray_item();
      end
   endtask

   // Result side: random stalls, ready stretches and one long hold-off.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         if (long_hold_due && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_BEGIN;
      csr_we = 1'b0;
      csr_wdata = '0;
      sent = 0;
      batch_left = 0;
      gap_on = 1'b1;
      calm = 1'b0;
      long_hold_due = 1'b0;
      long_hold_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Items out of sequence on an empty ring, and messages that never fit.
      send_item(CMD_READ, 12'h000, 8'h00);
      send_item(CMD_PAYLOAD, 12'hFFF, 8'hFF);
      send_item(CMD_FETCH, 12'h000, 8'h00);
      send_item(CMD_BEGIN, 12'hFFF, 8'hFF);
      send_item(CMD_BEGIN, 12'd4092, 8'h00);

      // An empty message commits at once; a second one stays open while a
      // stray begin and a fetch try to get in.
      send_item(CMD_BEGIN, 12'd0, 8'h00);
      send_item(CMD_BEGIN, 12'd3, 8'h00);
      send_item(CMD_BEGIN, 12'd0, 8'h00);
      send_item(CMD_FETCH, 12'd0, 8'h00);
      send_item(CMD_PAYLOAD, 12'd0, 8'h00);
      send_item(CMD_PAYLOAD, 12'hFFF, 8'hFF);
      send_item(CMD_PAYLOAD, 12'd0, 8'hA5);

      // Open a batch, try a second fetch, insert while the batch is open.
      send_item(CMD_FETCH, 12'd0, 8'h00);
      wait_reply();
      if (reply_status == RSP_OK) batch_left = reply_batch;
      send_item(CMD_FETCH, 12'd0, 8'h00);
      send_item(CMD_BEGIN, 12'd1, 8'h00);
      send_item(CMD_PAYLOAD, 12'd0, 8'h5A);
      repeat (4) begin
         send_item(CMD_READ, 12'd0, 8'h00);
         if (batch_left > 0) batch_left--;
      end

      // Random phases under different forward limits.
      set_limit(13'd0);
      run_phase(8, 30, 1'b0);
      set_limit(13'd1);
      run_phase(40, 40, 1'b0);
      set_limit(13'd64);
      run_phase(40, 40, 1'b0);
      // Queue up a few small messages with no effective forward limit.
      set_limit(13'd4096);
      run_phase(30, 0, 1'b1);
      // Drain the queued messages and carry on at random.
      set_limit(13'd4095);
      run_phase(60, 50, 1'b0);
      set_limit(LIMIT_W'($urandom_range(1, 4096)));
      calm = 1'b1;
      run_phase(60, 40, 1'b0);

      settle();
      if (fail_count == 0 && backlog == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/amrb_pkg.sv
rtl/core/amrb_ram.sv
rtl/core/amrb_ctrl.sv
rtl/core/amrb_dp.sv
rtl/core/aligned_message_ring_buffer_unit.sv
rtl/core/amrb_checker.sv
bench/amrb_ring_monitor.sv
bench/aligned_message_ring_buffer_unit_test.sv
